/* design/cfl_timestep_reduction_top_assert.svh */
// assertion macros for the cfl timestep reduction block
// used by cfl_timestep_reduction_top, expects i_clk and i_rst_n in scope
`ifndef CFL_TIMESTEP_REDUCTION_TOP_ASSERT_SVH
`define CFL_TIMESTEP_REDUCTION_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CFL_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("cfl check failed");
`define CFL_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) else $error("cfl check failed");
`else
`define CFL_ASSERT(lbl, prop)
`define CFL_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

/* design/cfl_pkg.sv */
// shared constants, register indexes and helpers for the cfl timestep block
// no dependencies
package cfl_pkg;

    localparam int WORD_W = 32;
    localparam int FRAC_W = 16;
    localparam int ADDR_W = 5;
    localparam logic [30:0] MAXV = 31'h7fffffff;
    localparam logic [18:0] ONE_Q = 19'(1 << FRAC_W);

    localparam logic [2:0] REG_MHD     = 3'd0;
    localparam logic [2:0] REG_ADIA    = 3'd1;
    localparam logic [2:0] REG_GAMMA   = 3'd2;
    localparam logic [2:0] REG_ISO     = 3'd3;
    localparam logic [2:0] REG_COUR    = 3'd4;
    localparam logic [2:0] REG_DX      = 3'd5;
    localparam logic [2:0] REG_DY      = 3'd6;
    localparam logic [2:0] REG_PFLOOR  = 3'd7;

    function automatic logic [31:0] mag32(input logic [31:0] x);
        mag32 = x[31] ? (~x + 32'd1) : x;
    endfunction

    function automatic logic [30:0] sat64(input logic [63:0] x);
        sat64 = (x[63:31] != '0) ? MAXV : x[30:0];
    endfunction

endpackage

/* design/cfl_if.sv */
// stream interfaces for cell input and timestep result
// depends on nothing
interface cfl_in_if;
    logic               valid;
    logic               ready;
    logic [30:0]        density;
    logic signed [31:0] momentum_x;
    logic signed [31:0] momentum_y;
    logic signed [31:0] momentum_z;
    logic signed [31:0] total_energy;
    logic signed [31:0] field_x;
    logic signed [31:0] field_y;
    logic signed [31:0] field_z;
    logic               last_cell;
    modport source (output valid, density, momentum_x, momentum_y, momentum_z,
                    total_energy, field_x, field_y, field_z, last_cell, input ready);
    modport sink   (input valid, density, momentum_x, momentum_y, momentum_z,
                    total_energy, field_x, field_y, field_z, last_cell, output ready);
endinterface

interface cfl_out_if;
    logic        valid;
    logic        ready;
    logic [30:0] max_signal_speed;
    logic [30:0] time_step;
    logic        speed_was_zero;
    modport source (output valid, max_signal_speed, time_step, speed_was_zero, input ready);
    modport sink   (input valid, max_signal_speed, time_step, speed_was_zero, output ready);
endinterface

/* design/cfl_timestep_reduction_top.sv */
// cfl timestep reduction: one cell per transfer, ready again once the cell is reduced
// (longest with mhd and adiabatic mode); the last cell also computes the time step
// a single shared divide/root unit serves every step,
// up to six divides and two roots a cell; the last cell adds one timestep divide
// synchronous active-low reset clears control, running maximum and registers
// to their reset values; no clearing pass
`include "cfl_timestep_reduction_top_assert.svh"
module cfl_timestep_reduction_top import cfl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cfl_in_if.sink            i_in,
    cfl_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_MSQ, ST_VDIV, ST_BGO, ST_BDIV, ST_BSQRT, ST_KGO, ST_KDIV,
        ST_PMUL, ST_GMUL, ST_GDIV, ST_CSQRT, ST_SUM, ST_TMUL, ST_TDIV, ST_DONE
    } t_state;

    t_state r_state;

    logic        r_mhd, r_adia;
    logic [18:0] r_gamma;
    logic [30:0] r_iso, r_dx, r_dy;
    logic [16:0] r_cour, r_pfloor;

    logic [30:0] r_d;
    logic [31:0] r_mom [3];
    logic [31:0] r_fld [3];
    logic [31:0] r_e;
    logic        r_last;
    logic [63:0] r_msq, r_bsq;
    logic [65:0] r_prod;
    logic [30:0] r_vmax, r_va, r_cs, r_max;
    logic [62:0] r_kin;
    logic [33:0] r_p;
    logic [2:0]  r_cnt;

    logic        r_ov, r_zero, r_ozero;
    logic [30:0] r_omax, r_dt, r_odt;

    logic        r_u_load, r_u_busy, r_u_sqrt, r_u_done;
    logic [5:0]  r_u_cnt;
    logic [33:0] r_rem;
    logic [63:0] r_acc, r_quo;
    logic [30:0] r_u_div;

    logic [33:0] mul_a;
    logic [31:0] mul_b;
    logic [65:0] mul_p;
    logic [31:0] sq_op;
    logic [18:0] gm1;
    logic signed [65:0] eint;
    logic [33:0] p_raw, p_flr;
    logic [30:0] h, v_sat;
    logic [32:0] speed;
    logic [30:0] speed_sat;
    logic [31:0] d_rem2;
    logic        d_ge;
    logic [33:0] s_rem2, s_trial;
    logic        s_ge;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[4:2])
            REG_MHD:    prdata = {31'd0, r_mhd};
            REG_ADIA:   prdata = {31'd0, r_adia};
            REG_GAMMA:  prdata = {13'd0, r_gamma};
            REG_ISO:    prdata = {1'b0, r_iso};
            REG_COUR:   prdata = {15'd0, r_cour};
            REG_DX:     prdata = {1'b0, r_dx};
            REG_DY:     prdata = {1'b0, r_dy};
            REG_PFLOOR: prdata = {15'd0, r_pfloor};
            default:    prdata = '0;
        endcase
    end

    // operand select for the shared multiplier
    always_comb begin
        sq_op = '0;
        if (r_cnt < 3'd3) begin
            sq_op = mag32(r_mom[r_cnt[1:0]]);
        end else if (r_cnt < 3'd6 && r_mhd) begin
            sq_op = mag32(r_fld[2'(r_cnt - 3'd3)]);
        end
        gm1 = (r_gamma > ONE_Q) ? (r_gamma - ONE_Q) : '0;
        eint = $signed({{34{r_e[31]}}, r_e}) - $signed({3'b0, r_kin})
             - $signed({19'b0, r_bsq[63:17]});
        h = (r_dx < r_dy) ? r_dx : r_dy;
        case (r_state)
            ST_PMUL: begin
                mul_a = {3'b0, eint[30:0]};
                mul_b = {13'b0, gm1};
            end
            ST_GMUL: begin
                mul_a = r_p;
                mul_b = {13'b0, r_gamma};
            end
            ST_TMUL: begin
                mul_a = {3'b0, h};
                mul_b = {15'b0, r_cour};
            end
            default: begin
                mul_a = {2'b0, sq_op};
                mul_b = sq_op;
            end
        endcase
        mul_p = mul_a * mul_b;
        p_raw = (!eint[65] && eint != '0) ? mul_p[49:16] : '0;
        p_flr = (p_raw < {17'b0, r_pfloor}) ? {17'b0, r_pfloor} : p_raw;
        v_sat = sat64(r_quo);
        speed = {2'b0, r_cs} + {2'b0, r_va} + {2'b0, r_vmax};
        speed_sat = (speed[32:31] != '0) ? MAXV : speed[30:0];
    end

    // one step of restoring divide or digit-by-digit root
    always_comb begin
        d_rem2  = {r_rem[30:0], r_acc[63]};
        d_ge    = d_rem2 >= {1'b0, r_u_div};
        s_rem2  = {r_rem[31:0], r_acc[63:62]};
        s_trial = {1'b0, r_quo[30:0], 2'b01};
        s_ge    = s_rem2 >= s_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_mhd    <= 1'b0;
            r_adia   <= 1'b1;
            r_gamma  <= 19'd109227;
            r_iso    <= 31'd65536;
            r_cour   <= 17'd52429;
            r_dx     <= 31'd65536;
            r_dy     <= MAXV;
            r_pfloor <= 17'd1;
            r_max    <= '0;
            r_ov     <= 1'b0;
            r_u_load <= 1'b0;
            r_u_busy <= 1'b0;
            r_u_done <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[4:2])
                    REG_MHD:    r_mhd    <= pwdata[0];
                    REG_ADIA:   r_adia   <= pwdata[0];
                    REG_GAMMA:  r_gamma  <= pwdata[18:0];
                    REG_ISO:    r_iso    <= pwdata[30:0];
                    REG_COUR:   r_cour   <= pwdata[16:0];
                    REG_DX:     r_dx     <= pwdata[30:0];
                    REG_DY:     r_dy     <= pwdata[30:0];
                    REG_PFLOOR: r_pfloor <= pwdata[16:0];
                    default:    r_mhd    <= r_mhd;
                endcase
            end

            if (o_out.valid && o_out.ready && r_state != ST_DONE) begin
                r_ov <= 1'b0;
            end

            // shared divide / root unit
            if (r_u_load) begin
                r_u_load <= 1'b0;
                r_u_busy <= 1'b1;
                r_u_cnt  <= r_u_sqrt ? 6'd30 : 6'd63;
                r_rem    <= '0;
                r_quo    <= '0;
                r_u_done <= 1'b0;
            end else if (r_u_busy) begin
                if (r_u_sqrt) begin
                    r_rem <= s_ge ? (s_rem2 - s_trial) : s_rem2;
                    r_acc <= {r_acc[61:0], 2'b00};
                    r_quo <= {r_quo[62:0], s_ge};
                end else begin
                    r_rem <= 34'(d_ge ? (d_rem2 - {1'b0, r_u_div}) : d_rem2);
                    r_acc <= {r_acc[62:0], 1'b0};
                    r_quo <= {r_quo[62:0], d_ge};
                end
                if (r_u_cnt == '0) begin
                    r_u_busy <= 1'b0;
                    r_u_done <= 1'b1;
                end else begin
                    r_u_cnt  <= r_u_cnt - 6'd1;
                    r_u_done <= 1'b0;
                end
            end else begin
                r_u_done <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_d      <= (i_in.density == '0) ? 31'd1 : i_in.density;
                        r_mom[0] <= i_in.momentum_x;
                        r_mom[1] <= i_in.momentum_y;
                        r_mom[2] <= i_in.momentum_z;
                        r_fld[0] <= i_in.field_x;
                        r_fld[1] <= i_in.field_y;
                        r_fld[2] <= i_in.field_z;
                        r_e      <= i_in.total_energy;
                        r_last   <= i_in.last_cell;
                        r_msq    <= '0;
                        r_bsq    <= '0;
                        r_vmax   <= '0;
                        r_va     <= '0;
                        r_kin    <= '0;
                        r_cnt    <= '0;
                        r_state  <= ST_MSQ;
                    end
                end
                ST_MSQ: begin
                    r_prod <= mul_p;
                    if (r_cnt >= 3'd1 && r_cnt <= 3'd3) begin
                        r_msq <= r_msq + r_prod[63:0];
                    end else if (r_cnt >= 3'd4) begin
                        r_bsq <= r_bsq + r_prod[63:0];
                    end
                    if (r_cnt == 3'd6) begin
                        r_cnt    <= '0;
                        r_u_load <= 1'b1;
                        r_u_sqrt <= 1'b0;
                        r_acc    <= {16'b0, mag32(r_mom[0]), 16'b0};
                        r_u_div  <= r_d;
                        r_state  <= ST_VDIV;
                    end else begin
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
                ST_VDIV: begin
                    if (r_u_done) begin
                        if (v_sat > r_vmax) begin
                            r_vmax <= v_sat;
                        end
                        if (r_cnt < 3'd2) begin
                            r_cnt    <= r_cnt + 3'd1;
                            r_u_load <= 1'b1;
                            r_acc    <= {16'b0, mag32(r_mom[2'(r_cnt + 3'd1)]), 16'b0};
                        end else begin
                            r_state <= ST_BGO;
                        end
                    end
                end
                ST_BGO: begin
                    if (r_mhd) begin
                        r_u_load <= 1'b1;
                        r_u_sqrt <= 1'b0;
                        r_acc    <= r_bsq;
                        r_state  <= ST_BDIV;
                    end else begin
                        r_state <= ST_KGO;
                    end
                end
                ST_BDIV: begin
                    if (r_u_done) begin
                        if (r_quo[63:46] != '0) begin
                            r_va    <= MAXV;
                            r_state <= ST_KGO;
                        end else begin
                            r_u_load <= 1'b1;
                            r_u_sqrt <= 1'b1;
                            r_acc    <= {r_quo[45:0], 18'b0};
                            r_state  <= ST_BSQRT;
                        end
                    end
                end
                ST_BSQRT: begin
                    if (r_u_done) begin
                        r_va    <= r_quo[30:0];
                        r_state <= ST_KGO;
                    end
                end
                ST_KGO: begin
                    if (r_adia) begin
                        r_u_load <= 1'b1;
                        r_u_sqrt <= 1'b0;
                        r_acc    <= r_msq;
                        r_state  <= ST_KDIV;
                    end else begin
                        r_cs    <= r_iso;
                        r_state <= ST_SUM;
                    end
                end
                ST_KDIV: begin
                    if (r_u_done) begin
                        r_kin   <= r_quo[63:1];
                        r_state <= ST_PMUL;
                    end
                end
                ST_PMUL: begin
                    r_p     <= p_flr;
                    r_state <= ST_GMUL;
                end
                ST_GMUL: begin
                    r_u_load <= 1'b1;
                    r_u_sqrt <= 1'b0;
                    r_acc    <= mul_p[63:0];
                    r_state  <= ST_GDIV;
                end
                ST_GDIV: begin
                    if (r_u_done) begin
                        if (r_quo[63:46] != '0) begin
                            r_cs    <= MAXV;
                            r_state <= ST_SUM;
                        end else begin
                            r_u_load <= 1'b1;
                            r_u_sqrt <= 1'b1;
                            r_acc    <= {r_quo[45:0], 18'b0};
                            r_state  <= ST_CSQRT;
                        end
                    end
                end
                ST_CSQRT: begin
                    if (r_u_done) begin
                        r_cs    <= r_quo[30:0];
                        r_state <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    if (speed_sat > r_max) begin
                        r_max <= speed_sat;
                    end
                    r_state <= r_last ? ST_TMUL : ST_IDLE;
                end
                ST_TMUL: begin
                    if (r_max == '0) begin
                        r_dt    <= MAXV;
                        r_zero  <= 1'b1;
                        r_state <= ST_DONE;
                    end else begin
                        r_zero   <= 1'b0;
                        r_u_load <= 1'b1;
                        r_u_sqrt <= 1'b0;
                        r_acc    <= {16'b0, mul_p[47:0]};
                        r_u_div  <= r_max;
                        r_state  <= ST_TDIV;
                    end
                end
                ST_TDIV: begin
                    if (r_u_done) begin
                        r_dt    <= v_sat;
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_ov || o_out.ready) begin
                        r_ov    <= 1'b1;
                        r_omax  <= r_max;
                        r_odt   <= r_dt;
                        r_ozero <= r_zero;
                        r_max   <= '0;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign i_in.ready             = (r_state == ST_IDLE);
    assign o_out.valid            = r_ov;
    assign o_out.max_signal_speed = r_omax;
    assign o_out.time_step        = r_odt;
    assign o_out.speed_was_zero   = r_ozero;

    `CFL_ASSERT(a_ready_unit_free, i_in.ready |-> (!r_u_busy && !r_u_load))
    `CFL_ASSERT(a_zero_saturates, (o_out.valid && o_out.speed_was_zero) |-> (o_out.time_step == MAXV))
    `CFL_ASSERT(a_max_cleared, (r_state == ST_IDLE && $past(r_state) == ST_DONE) |-> (r_max == '0))
    `CFL_ASSERT(a_done_not_busy, r_u_done |-> !r_u_busy)

endmodule
